FILE: rtl/dsab_pkg.sv
// Shared types and constants for the detection score argmax and box scale block.
`timescale 1ns / 1ps
package dsab_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_X          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_Y          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd6;

    // Item kinds.
    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_SCORE = 1'b1;

    // Argmax start values: minus one in Q4.12 and "no class".
    localparam logic signed [15:0] INIT_BEST  = 16'shF000;
    localparam logic signed [7:0]  CLASS_NONE = 8'shFF;

    // Configuration reset values.
    localparam logic [7:0]         RST_NUM_CLASSES    = 8'd80;
    localparam logic signed [15:0] RST_CONF_THRESHOLD = 16'sd1024;
    localparam logic [15:0]        RST_INV_GAIN       = 16'd4096;
    localparam logic [13:0]        RST_IMAGE_SIZE     = 14'd640;

    localparam int PROD_W = 34;

    typedef struct packed {
        logic [7:0]         num_classes;
        logic signed [15:0] conf_threshold;
        logic [15:0]        inv_gain;
        logic signed [15:0] pad_x;
        logic signed [15:0] pad_y;
        logic [13:0]        image_width;
        logic [13:0]        image_height;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] score;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
    } item_t;

    typedef struct packed {
        logic                     kind;
        logic signed [15:0]       score;
        logic signed [PROD_W-1:0] prod_left;
        logic signed [PROD_W-1:0] prod_top;
        logic signed [PROD_W-1:0] prod_right;
        logic signed [PROD_W-1:0] prod_bottom;
    } prod_t;

    typedef struct packed {
        logic [14:0]        out_left;
        logic [14:0]        out_top;
        logic signed [15:0] out_right;
        logic signed [15:0] out_bottom;
        logic signed [7:0]  class_index;
        logic signed [15:0] confidence;
    } result_t;

endpackage

FILE: rtl/dsab_if.sv
// Channel interfaces: input items, detection results and configuration writes.
`timescale 1ns / 1ps
interface dsab_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] score;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [15:0] box_right;
    logic signed [15:0] box_bottom;

    modport source (output valid, kind, score, box_left, box_top, box_right, box_bottom,
                    input ready);
    modport sink (input valid, kind, score, box_left, box_top, box_right, box_bottom,
                  output ready);
endinterface

interface dsab_result_if;
    logic               valid;
    logic               ready;
    logic [14:0]        out_left;
    logic [14:0]        out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic signed [7:0]  class_index;
    logic signed [15:0] confidence;

    modport source (output valid, out_left, out_top, out_right, out_bottom, class_index,
                    confidence, input ready);
    modport sink (input valid, out_left, out_top, out_right, out_bottom, class_index,
                  confidence, output ready);
endinterface

interface dsab_cfg_if;
    import dsab_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/dsab_box_mul.sv
// Multiply stage: subtracts the padding and multiplies each corner by the inverse gain.
`timescale 1ns / 1ps
module dsab_box_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dsab_pkg::item_t  in_item,
    input  dsab_pkg::cfg_t   cfg,
    output logic             prod_valid,
    input  logic             prod_ready,
    output dsab_pkg::prod_t  prod
);
    import dsab_pkg::*;

    logic  prod_valid_reg;
    logic  prod_valid_next;
    prod_t prod_reg;
    prod_t prod_next;

    // One lane: 17-bit signed difference times 17-bit non-negative gain.
    function automatic logic signed [PROD_W-1:0] scale_mul(
        input logic signed [15:0] raw,
        input logic signed [15:0] pad,
        input logic [15:0]        gain
    );
        logic signed [16:0] diff;
        logic signed [16:0] gain_s;
        diff   = $signed({raw[15], raw}) - $signed({pad[15], pad});
        gain_s = $signed({1'b0, gain});
        return PROD_W'(diff * gain_s);
    endfunction

    assign in_ready = !prod_valid_reg || prod_ready;

    // Four independent multiplier lanes, results registered.
    always_comb
    begin
        prod_next.kind        = in_item.kind;
        prod_next.score       = in_item.score;
        prod_next.prod_left   = scale_mul(in_item.box_left, cfg.pad_x, cfg.inv_gain);
        prod_next.prod_top    = scale_mul(in_item.box_top, cfg.pad_y, cfg.inv_gain);
        prod_next.prod_right  = scale_mul(in_item.box_right, cfg.pad_x, cfg.inv_gain);
        prod_next.prod_bottom = scale_mul(in_item.box_bottom, cfg.pad_y, cfg.inv_gain);
    end

    // The stage fills on an input transaction and empties when the decode stage takes it.
    always_comb
    begin
        if (in_valid && in_ready)
        begin
            prod_valid_next = 1'b1;
        end
        else if (prod_ready)
        begin
            prod_valid_next = 1'b0;
        end
        else
        begin
            prod_valid_next = prod_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

FILE: rtl/dsab_decode.sv
// Decode stage: box rounding and clipping, running argmax, threshold and result register.
`timescale 1ns / 1ps
module dsab_decode #(
    parameter int MAX_CLASSES = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              prod_valid,
    output logic              prod_ready,
    input  dsab_pkg::prod_t   prod,
    input  dsab_pkg::cfg_t    cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output dsab_pkg::result_t result
);
    import dsab_pkg::*;

    // The class count never passes what the 8-bit register allows.
    localparam int LIMIT_MAX = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
    localparam int CNT_W     = (LIMIT_MAX < 2) ? 1 : $clog2(LIMIT_MAX + 1);

    logic signed [15:0] box_left_reg,   box_left_next;
    logic signed [15:0] box_top_reg,    box_top_next;
    logic signed [15:0] box_right_reg,  box_right_next;
    logic signed [15:0] box_bottom_reg, box_bottom_next;
    logic signed [15:0] best_score_reg, best_score_next;
    logic signed [7:0]  best_class_reg, best_class_next;
    logic [CNT_W-1:0]   score_count_reg, score_count_next;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;

    logic               take;
    logic               emit;
    logic               cnt_full;
    logic               better;
    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   cnt_inc;
    logic signed [15:0] cand_score;
    logic signed [7:0]  cand_class;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;

    // Truncate the Q16 product toward zero and saturate to signed 16 bits.
    function automatic logic signed [15:0] to_pixel(input logic signed [PROD_W-1:0] p);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [17:0]       shifted;
        logic signed [18:0] q;
        neg     = p[PROD_W-1];
        mag     = neg ? PROD_W'(-p) : PROD_W'(p);
        shifted = mag[PROD_W-1:16];
        q       = neg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
        if (q > 19'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (q < -19'sd32768)
        begin
            return 16'sh8000;
        end
        else
        begin
            return q[15:0];
        end
    endfunction

    // Clip a left or top edge at zero.
    function automatic logic signed [15:0] clip_low(input logic signed [15:0] v);
        return v[15] ? 16'sd0 : v;
    endfunction

    // Clip a right or bottom edge at the image size minus one.
    function automatic logic signed [15:0] clip_high(
        input logic signed [15:0] v,
        input logic [13:0]        size
    );
        logic signed [16:0] bound;
        bound = $signed({3'b000, size}) - 17'sd1;
        if ($signed({v[15], v}) >= $signed({3'b000, size}))
        begin
            return bound[15:0];
        end
        else
        begin
            return v;
        end
    endfunction

    // Box corners in image pixels.
    always_comb
    begin
        x1 = clip_low(to_pixel(prod.prod_left));
        y1 = clip_low(to_pixel(prod.prod_top));
        x2 = clip_high(to_pixel(prod.prod_right), cfg.image_width);
        y2 = clip_high(to_pixel(prod.prod_bottom), cfg.image_height);
    end

    // Running argmax step and the end-of-anchor threshold check.
    always_comb
    begin
        limit      = (cfg.num_classes > 8'(LIMIT_MAX)) ? CNT_W'(LIMIT_MAX)
                                                        : CNT_W'(cfg.num_classes);
        cnt_full   = score_count_reg >= limit;
        cnt_inc    = score_count_reg + CNT_W'(1);
        better     = prod.score > best_score_reg;
        cand_score = better ? prod.score : best_score_reg;
        cand_class = better ? 8'(score_count_reg) : best_class_reg;
        emit       = (prod.kind == KIND_SCORE) && !cnt_full && (cnt_inc == limit)
                     && (cand_score >= cfg.conf_threshold);
    end

    // A result may enter only when the result register is free or being read.
    assign prod_ready = !emit || !out_valid_reg || out_ready;
    assign take       = prod_valid && prod_ready;

    // State update for the anchor in progress.
    always_comb
    begin
        box_left_next    = box_left_reg;
        box_top_next     = box_top_reg;
        box_right_next   = box_right_reg;
        box_bottom_next  = box_bottom_reg;
        best_score_next  = best_score_reg;
        best_class_next  = best_class_reg;
        score_count_next = score_count_reg;
        if (take)
        begin
            if (prod.kind == KIND_BOX)
            begin
                box_left_next    = x1;
                box_top_next     = y1;
                box_right_next   = x2;
                box_bottom_next  = y2;
                best_score_next  = INIT_BEST;
                best_class_next  = CLASS_NONE;
                score_count_next = '0;
            end
            else if (!cnt_full)
            begin
                best_score_next  = cand_score;
                best_class_next  = cand_class;
                score_count_next = cnt_inc;
            end
        end
    end

    // Result register loads on an emitting transaction and clears when read.
    always_comb
    begin
        result_next.out_left    = box_left_reg[14:0];
        result_next.out_top     = box_top_reg[14:0];
        result_next.out_right   = box_right_reg;
        result_next.out_bottom  = box_bottom_reg;
        result_next.class_index = cand_class;
        result_next.confidence  = cand_score;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg    <= '0;
            box_top_reg     <= '0;
            box_right_reg   <= '0;
            box_bottom_reg  <= '0;
            best_score_reg  <= INIT_BEST;
            best_class_reg  <= CLASS_NONE;
            score_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            box_left_reg    <= box_left_next;
            box_top_reg     <= box_top_next;
            box_right_reg   <= box_right_next;
            box_bottom_reg  <= box_bottom_next;
            best_score_reg  <= best_score_next;
            best_class_reg  <= best_class_next;
            score_count_reg <= score_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // The class counter stays within the largest class limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        score_count_reg <= CNT_W'(LIMIT_MAX))
        else $error("score count beyond class limit");

    // A box transaction restarts the argmax.
    a_box_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && prod.kind == KIND_BOX) |=> (score_count_reg == '0 &&
        best_class_reg == CLASS_NONE))
        else $error("box did not restart argmax");

    // Without a winning class the best score is still the start value.
    a_none_init: assert property (@(posedge clk) disable iff (!rst_n)
        (best_class_reg == CLASS_NONE) |-> (best_score_reg == INIT_BEST))
        else $error("best score moved without a class");

    // An emitting transaction shows a result in the next cycle.
    a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit) |=> out_valid_reg)
        else $error("emitted result not presented");

endmodule

FILE: rtl/detection_score_argmax_box_scale.sv
// Top level of the detection score argmax and box scale block.
`timescale 1ns / 1ps
// Channel     Modport   Transaction carries
// cfg         sink      register index, 16-bit write data
// anchor      sink      kind, score, box_left, box_top, box_right, box_bottom
// detection   source    out_left, out_top, out_right, out_bottom, class_index, confidence
//
// One item is accepted per cycle while anchor.ready is high; it passes an input register,
// the four-lane multiplier register and the argmax/decode stage, and the detection of an
// anchor enters the output register as the last score item of that anchor is decoded.
// Reset (rst_n low, asynchronous) empties all stages and loads the register defaults.
// Only an item that would emit waits while an unread result sits in the output register;
// that stall then backs up through the stages to anchor.ready.
module detection_score_argmax_box_scale #(
    parameter int MAX_CLASSES = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    dsab_cfg_if.sink      cfg,
    dsab_item_if.sink     anchor,
    dsab_result_if.source detection
);
    import dsab_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    mul_ready;
    logic    prod_valid;
    logic    prod_ready;
    prod_t   prod;
    result_t result;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_NUM_CLASSES:    cfg_next.num_classes    = cfg.data[7:0];
                REG_CONF_THRESHOLD: cfg_next.conf_threshold = $signed(cfg.data);
                REG_INV_GAIN:       cfg_next.inv_gain       = cfg.data;
                REG_PAD_X:          cfg_next.pad_x          = $signed(cfg.data);
                REG_PAD_Y:          cfg_next.pad_y          = $signed(cfg.data);
                REG_IMAGE_WIDTH:    cfg_next.image_width    = cfg.data[13:0];
                REG_IMAGE_HEIGHT:   cfg_next.image_height   = cfg.data[13:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_classes    <= RST_NUM_CLASSES;
            cfg_reg.conf_threshold <= RST_CONF_THRESHOLD;
            cfg_reg.inv_gain       <= RST_INV_GAIN;
            cfg_reg.pad_x          <= '0;
            cfg_reg.pad_y          <= '0;
            cfg_reg.image_width    <= RST_IMAGE_SIZE;
            cfg_reg.image_height   <= RST_IMAGE_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register in front of the multiplier stage.
    assign anchor.ready = !in_valid_reg || mul_ready;

    always_comb
    begin
        in_item_next.kind       = anchor.kind;
        in_item_next.score      = anchor.score;
        in_item_next.box_left   = anchor.box_left;
        in_item_next.box_top    = anchor.box_top;
        in_item_next.box_right  = anchor.box_right;
        in_item_next.box_bottom = anchor.box_bottom;
        if (anchor.valid && anchor.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (mul_ready)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (anchor.valid && anchor.ready)
        begin
            in_item_reg <= in_item_next;
        end
    end

    dsab_box_mul u_box_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .in_ready   (mul_ready),
        .in_item    (in_item_reg),
        .cfg        (cfg_reg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    dsab_decode #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .cfg        (cfg_reg),
        .out_valid  (detection.valid),
        .out_ready  (detection.ready),
        .result     (result)
    );

    // Result fields onto the detection channel.
    assign detection.out_left    = result.out_left;
    assign detection.out_top     = result.out_top;
    assign detection.out_right   = result.out_right;
    assign detection.out_bottom  = result.out_bottom;
    assign detection.class_index = result.class_index;
    assign detection.confidence  = result.confidence;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the detection score argmax and box scale block.
`timescale 1ns / 1ps
module tb_top;
    import dsab_pkg::*;

    localparam int MAX_CLASSES = 128;
    // Index past the last register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // Pipeline depth plus margin, for items that never produce a detection.
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 128;

    logic clk;
    logic rst_n;

    dsab_cfg_if    cfg_bus ();
    dsab_item_if   anchor_bus ();
    dsab_result_if det_bus ();

    detection_score_argmax_box_scale #(.MAX_CLASSES(MAX_CLASSES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .anchor    (anchor_bus),
        .detection (det_bus)
    );

    // Shadow copy of the registers and of the decode state.
    cfg_t               regs;
    logic signed [15:0] best_score;
    logic signed [7:0]  best_class;
    int                 score_count;
    int                 kept_box [4];

    item_t   anchor_items [$];
    item_t   cur_item;
    result_t due_detections [$];
    result_t detection_seen;
    result_t detection_due;

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int n_items;
    int n_boxes;
    int n_detections;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Scale one corner: remove padding, multiply by the inverse gain, truncate toward
    // zero and saturate to 16 bits.
    function automatic int scale_corner(logic signed [15:0] raw, logic signed [15:0] pad);
        longint diff;
        longint prod;
        longint q;
        diff = longint'(raw) - longint'(pad);
        prod = diff * longint'(regs.inv_gain);
        if (prod < 0)
            q = -((-prod) >>> 16);
        else
            q = prod >>> 16;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return int'(q);
    endfunction

    // Advance the decode state by one accepted item and queue any detection it completes.
    task automatic decode_anchor_item(input item_t it);
        int      limit;
        result_t r;
        if (it.kind == KIND_BOX)
        begin
            kept_box[0] = scale_corner(it.box_left, regs.pad_x);
            kept_box[1] = scale_corner(it.box_top, regs.pad_y);
            kept_box[2] = scale_corner(it.box_right, regs.pad_x);
            kept_box[3] = scale_corner(it.box_bottom, regs.pad_y);
            if (kept_box[0] < 0)
                kept_box[0] = 0;
            if (kept_box[1] < 0)
                kept_box[1] = 0;
            if (kept_box[2] >= int'(regs.image_width))
                kept_box[2] = int'(regs.image_width) - 1;
            if (kept_box[3] >= int'(regs.image_height))
                kept_box[3] = int'(regs.image_height) - 1;
            best_score  = INIT_BEST;
            best_class  = CLASS_NONE;
            score_count = 0;
            n_boxes++;
        end
        else
        begin
            limit = (int'(regs.num_classes) < MAX_CLASSES) ? int'(regs.num_classes)
                                                            : MAX_CLASSES;
            // Scores past the class limit change nothing until the next box.
            if (score_count < limit)
            begin
                if (best_score < it.score)
                begin
                    best_score = it.score;
                    best_class = 8'(score_count);
                end
                score_count++;
                if (score_count == limit && best_score >= regs.conf_threshold)
                begin
                    r.out_left    = 15'(kept_box[0]);
                    r.out_top     = 15'(kept_box[1]);
                    r.out_right   = 16'(kept_box[2]);
                    r.out_bottom  = 16'(kept_box[3]);
                    r.class_index = best_class;
                    r.confidence  = best_score;
                    due_detections.push_back(r);
                end
            end
        end
    endtask

    task automatic report_failure(input string what, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t %s: expected (%0d,%0d,%0d,%0d) class %0d conf %0d",
                     $time, what, want.out_left, want.out_top, want.out_right,
                     want.out_bottom, want.class_index, want.confidence);
            $display("    got (%0d,%0d,%0d,%0d) class %0d conf %0d",
                     got.out_left, got.out_top, got.out_right, got.out_bottom,
                     got.class_index, got.confidence);
        end
    endtask

    // Driver: holds each transaction until it is accepted and idles at random between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_bus.valid <= 1'b0;
        end
        else
        begin
            if (anchor_bus.valid && anchor_bus.ready)
            begin
                decode_anchor_item(cur_item);
                n_items++;
            end
            if (!anchor_bus.valid || anchor_bus.ready)
            begin
                if (anchor_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = anchor_items.pop_front();
                    anchor_bus.valid      <= 1'b1;
                    anchor_bus.kind       <= cur_item.kind;
                    anchor_bus.score      <= cur_item.score;
                    anchor_bus.box_left   <= cur_item.box_left;
                    anchor_bus.box_top    <= cur_item.box_top;
                    anchor_bus.box_right  <= cur_item.box_right;
                    anchor_bus.box_bottom <= cur_item.box_bottom;
                end
                else
                    anchor_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each detection against the oldest one predicted and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_bus.ready <= 1'b0;
        end
        else
        begin
            if (det_bus.valid && det_bus.ready)
            begin
                detection_seen.out_left    = det_bus.out_left;
                detection_seen.out_top     = det_bus.out_top;
                detection_seen.out_right   = det_bus.out_right;
                detection_seen.out_bottom  = det_bus.out_bottom;
                detection_seen.class_index = det_bus.class_index;
                detection_seen.confidence  = det_bus.confidence;
                n_detections++;
                if (due_detections.size() == 0)
                begin
                    report_failure("detection with none pending", '0, detection_seen);
                end
                else
                begin
                    detection_due = due_detections.pop_front();
                    if (detection_seen !== detection_due)
                        report_failure("detection mismatch", detection_due, detection_seen);
                end
            end
            det_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One register write transaction; called at a rising edge, leaves valid high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_NUM_CLASSES:    regs.num_classes    = value[7:0];
            REG_CONF_THRESHOLD: regs.conf_threshold = value;
            REG_INV_GAIN:       regs.inv_gain       = value;
            REG_PAD_X:          regs.pad_x          = value;
            REG_PAD_Y:          regs.pad_y          = value;
            REG_IMAGE_WIDTH:    regs.image_width    = value[13:0];
            REG_IMAGE_HEIGHT:   regs.image_height   = value[13:0];
            default: ;
        endcase
    endtask

    // Write every register; the unused upper data bits carry random values.
    task automatic apply_cfg(input cfg_t c);
        @(posedge clk);
        write_reg(REG_NUM_CLASSES, {8'($urandom), c.num_classes});
        write_reg(REG_CONF_THRESHOLD, c.conf_threshold);
        write_reg(REG_INV_GAIN, c.inv_gain);
        write_reg(REG_PAD_X, c.pad_x);
        write_reg(REG_PAD_Y, c.pad_y);
        write_reg(REG_IMAGE_WIDTH, {2'($urandom), c.image_width});
        write_reg(REG_IMAGE_HEIGHT, {2'($urandom), c.image_height});
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every item is taken and every detection has come back.
    task automatic wait_drain();
        do
            @(negedge clk);
        while (anchor_items.size() != 0 || anchor_bus.valid || due_detections.size() != 0);
        // Items that produce nothing may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic item_t box_item(logic signed [15:0] l, logic signed [15:0] t,
                                       logic signed [15:0] r, logic signed [15:0] b);
        item_t it;
        it.kind       = KIND_BOX;
        it.score      = 16'($urandom);
        it.box_left   = l;
        it.box_top    = t;
        it.box_right  = r;
        it.box_bottom = b;
        return it;
    endfunction

    function automatic item_t score_item(logic signed [15:0] s);
        item_t it;
        it.kind       = KIND_SCORE;
        it.score      = s;
        it.box_left   = 16'($urandom);
        it.box_top    = 16'($urandom);
        it.box_right  = 16'($urandom);
        it.box_bottom = 16'($urandom);
        return it;
    endfunction

    function automatic logic signed [15:0] random_corner();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Scores lean toward a few values so that ties and the start value come up often.
    function automatic logic signed [15:0] random_score();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return INIT_BEST;
            3:       return INIT_BEST - 16'sd1;
            4:       return 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one anchor: mostly complete, sometimes cut short, sometimes with extra scores.
    task automatic push_anchor(input int limit, output int counted);
        int n;
        int shape;
        shape = $urandom_range(0, 9);
        anchor_items.push_back(box_item(random_corner(), random_corner(), random_corner(),
                                        random_corner()));
        if (shape < 8)
            n = limit;
        else if (shape == 8)
            n = $urandom_range(0, limit - 1);
        else
            n = limit + $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            anchor_items.push_back(score_item(random_score()));
        counted = 1 + ((n < limit) ? n : limit);
    endtask

    // Register settings of each random phase, extremes included.
    function automatic cfg_t phase_settings(int p);
        cfg_t c;
        c.num_classes    = 8'($urandom_range(1, 8));
        c.conf_threshold = 16'($urandom_range(0, 8192) - 4096);
        c.inv_gain       = 16'($urandom);
        c.pad_x          = 16'($urandom_range(0, 2048) - 1024);
        c.pad_y          = 16'($urandom_range(0, 2048) - 1024);
        c.image_width    = 14'($urandom_range(1, 8192));
        c.image_height   = 14'($urandom_range(1, 8192));
        case (p)
            0:
            begin
                c.conf_threshold = 16'($urandom_range(0, 4096));
                c.inv_gain       = RST_INV_GAIN;
                c.pad_x          = '0;
                c.pad_y          = '0;
                c.image_width    = RST_IMAGE_SIZE;
                c.image_height   = RST_IMAGE_SIZE;
            end
            1:
            begin
                c.num_classes    = 8'd1;
                c.conf_threshold = 16'sh8000;
                c.inv_gain       = 16'hFFFF;
                c.pad_x          = 16'sh7FFF;
                c.pad_y          = 16'sh8000;
                c.image_width    = 14'd8192;
                c.image_height   = 14'd1;
            end
            2:
                c.conf_threshold = 16'sh7FFF;
            3:
            begin
                c.num_classes    = 8'd128;
                c.conf_threshold = '0;
                c.inv_gain       = 16'd1;
                c.image_width    = 14'h3FFF;
                c.image_height   = 14'h3FFF;
            end
            4:
            begin
                c.num_classes  = 8'd255;
                c.pad_x        = 16'($urandom);
                c.pad_y        = 16'($urandom);
                c.image_width  = 14'($urandom);
                c.image_height = 14'($urandom);
            end
            5:
                c.inv_gain = '0;
            6:
            begin
                c.num_classes  = 8'($urandom_range(1, 12));
                c.pad_x        = 16'($urandom);
                c.pad_y        = 16'($urandom);
                c.image_width  = 14'($urandom);
                c.image_height = 14'($urandom);
            end
            default:
            begin
                c.conf_threshold = INIT_BEST;
                c.image_width    = '0;
                c.image_height   = '0;
            end
        endcase
        return c;
    endfunction

    // Stimulus: reset, directed cases, then random phases under changing settings.
    initial
    begin
        cfg_t c;
        int   done;
        int   counted;
        int   limit;
        bit   held;

        rst_n                 = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;
        anchor_bus.valid      = 1'b0;
        anchor_bus.kind       = KIND_BOX;
        anchor_bus.score      = '0;
        anchor_bus.box_left   = '0;
        anchor_bus.box_top    = '0;
        anchor_bus.box_right  = '0;
        anchor_bus.box_bottom = '0;
        det_bus.ready         = 1'b0;
        held                  = 1'b0;

        regs.num_classes    = RST_NUM_CLASSES;
        regs.conf_threshold = RST_CONF_THRESHOLD;
        regs.inv_gain       = RST_INV_GAIN;
        regs.pad_x          = '0;
        regs.pad_y          = '0;
        regs.image_width    = RST_IMAGE_SIZE;
        regs.image_height   = RST_IMAGE_SIZE;
        best_score          = INIT_BEST;
        best_class          = CLASS_NONE;
        score_count         = 0;
        for (int i = 0; i < 4; i++)
            kept_box[i] = 0;

        send_idle_pct = 37;
        recv_idle_pct = 80;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Two classes and the lowest threshold; scaling registers keep their reset values.
        @(posedge clk);
        write_reg(REG_NUM_CLASSES, {8'($urandom), 8'd2});
        write_reg(REG_CONF_THRESHOLD, 16'h8000);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);

        // Scores ahead of any box report the cleared box.
        anchor_items.push_back(score_item(16'sh7FFF));
        anchor_items.push_back(score_item(16'sh8000));
        // Corner extremes, then two scores that never beat the start value.
        anchor_items.push_back(box_item(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF));
        anchor_items.push_back(score_item(INIT_BEST));
        anchor_items.push_back(score_item(16'sh8000));
        // Equal scores: the first one wins; a third score past the limit is dropped.
        anchor_items.push_back(box_item(16'sd160, 16'sd320, 16'sd800, 16'sd16000));
        anchor_items.push_back(score_item(16'sd100));
        anchor_items.push_back(score_item(16'sd100));
        anchor_items.push_back(score_item(16'sh7FFF));
        wait_drain();

        // Saturating products, zero image size, threshold met exactly and missed.
        c                = regs;
        c.num_classes    = 8'd3;
        c.conf_threshold = 16'sd4096;
        c.inv_gain       = 16'hFFFF;
        c.pad_x          = 16'sh8000;
        c.pad_y          = 16'sh7FFF;
        c.image_width    = '0;
        c.image_height   = '0;
        apply_cfg(c);
        anchor_items.push_back(box_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
        anchor_items.push_back(score_item(16'sd4095));
        anchor_items.push_back(score_item(16'sd4096));
        anchor_items.push_back(score_item(16'sd4096));
        anchor_items.push_back(box_item(random_corner(), random_corner(), random_corner(),
                                        random_corner()));
        for (int i = 0; i < 3; i++)
            anchor_items.push_back(score_item(16'sd4095));
        wait_drain();

        // No classes and no gain: scores are ignored and nothing comes out.
        c.num_classes    = '0;
        c.inv_gain       = '0;
        c.conf_threshold = 16'sh8000;
        apply_cfg(c);
        anchor_items.push_back(box_item(random_corner(), random_corner(), random_corner(),
                                        random_corner()));
        anchor_items.push_back(score_item(random_score()));
        anchor_items.push_back(score_item(random_score()));
        wait_drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 37;
            end
            if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            c = phase_settings(p);
            apply_cfg(c);
            limit = (int'(c.num_classes) < MAX_CLASSES) ? int'(c.num_classes) : MAX_CLASSES;
            done  = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                push_anchor(limit, counted);
                done += counted;
                // Hold the sender once mid phase until every detection has come back.
                if (p == 2 && !held && done >= ITEMS_PER_PHASE / 2)
                begin
                    wait_drain();
                    held = 1'b1;
                end
            end
            wait_drain();
        end

        repeat (20) @(negedge clk);
        $display("Covered %0d items (%0d boxes) over directed cases and %0d register settings,",
                 n_items, n_boxes, PHASES);
        $display("with %0d detections checked under both stall ratios and with no stalls.",
                 n_detections);
        if (fail_count == 0 && due_detections.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
